### rtl/core/assert_macros.svh
// assertion helpers for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked outside reset
`define ABK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define ABK_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/abk_pkg.sv
package abk_pkg;

  localparam int unsigned CovFracBits = 24;
  localparam int unsigned DtFracBits  = 24;

  localparam logic [30:0] QAngleReset   = 31'((64'd1 << CovFracBits) * 1 / 1000);
  localparam logic [30:0] QBiasReset    = 31'((64'd1 << CovFracBits) * 3 / 1000);
  localparam logic [30:0] RMeasureReset = 31'((64'd1 << CovFracBits) * 3 / 100);
  localparam logic [31:0] P11Seed       = 32'((64'd1 << CovFracBits) * 2 / 100);

  typedef enum logic [1:0] {
    CFG_Q_ANGLE   = 2'd0,
    CFG_Q_BIAS    = 2'd1,
    CFG_R_MEASURE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_RESET  = 1'b1
  } kind_e;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] measured_angle;
    logic signed [31:0] gyro_rate;
    logic        [23:0] time_step;
    logic signed [31:0] seed_angle;
    logic signed [31:0] seed_bias;
  } in_t;

  typedef struct packed {
    logic signed [31:0] filtered_angle;
    logic signed [31:0] corrected_rate;
  } out_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] gain;
  } div_rsp_t;

  typedef enum logic [2:0] {
    DS_IDLE,
    DS_PREP,
    DS_CHK,
    DS_RUN,
    DS_FIN
  } div_st_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ANG,
    ST_T,
    ST_QB,
    ST_P00,
    ST_WB_P00,
    ST_S,
    ST_DIV0,
    ST_DIV1,
    ST_K0Y,
    ST_K1Y,
    ST_K0P00,
    ST_K0P01,
    ST_K1P00,
    ST_K1P01,
    ST_WB_LAST,
    ST_OUT
  } st_e;

  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_ANG,
    MOP_T,
    MOP_QB,
    MOP_P00,
    MOP_K0Y,
    MOP_K1Y,
    MOP_K0P00,
    MOP_K0P01,
    MOP_K1P00,
    MOP_K1P01
  } mop_e;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/abk_mul.sv
module abk_mul (
  input  logic               clk_i,
  input  logic signed [34:0] a_i,
  input  logic signed [32:0] b_i,
  input  logic               cov_i,
  output logic signed [43:0] rnd_o
);

  logic signed [67:0] prod_q;
  logic               cov_q;
  logic signed [67:0] sum_dt;
  logic signed [67:0] sum_cov;
  logic signed [67:0] sh;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    cov_q  <= cov_i;
  end

  // round to nearest, ties toward plus infinity
  assign sum_dt  = prod_q + (68'sd1 <<< (abk_pkg::DtFracBits - 1));
  assign sum_cov = prod_q + (68'sd1 <<< (abk_pkg::CovFracBits - 1));
  assign sh      = cov_q ? (sum_cov >>> abk_pkg::CovFracBits)
                         : (sum_dt >>> abk_pkg::DtFracBits);
  assign rnd_o   = sh[43:0];

endmodule

### rtl/core/abk_div.sv
module abk_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  abk_pkg::div_req_t  req_i,
  output abk_pkg::div_rsp_t  rsp_o
);

  abk_pkg::div_st_e st_q, st_d;
  logic        [31:0] na_q;
  logic        [32:0] da_q;
  logic               neg_q;
  logic               sat_q;
  logic        [32:0] rem_q;
  logic        [31:0] nlo_q;
  logic        [31:0] quo_q;
  logic        [4:0]  cnt_q;
  logic        [55:0] n_full;
  logic               ovf;
  logic        [34:0] trial;

  assign n_full = {na_q, 24'd0} + {23'd0, da_q[32:1]};
  assign ovf    = {8'd0, n_full} >= {da_q, 31'd0};
  assign trial  = {1'b0, rem_q, nlo_q[31]} - {2'd0, da_q};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      abk_pkg::DS_IDLE, abk_pkg::DS_FIN: begin
        st_d = req_i.start ? abk_pkg::DS_PREP : abk_pkg::DS_IDLE;
      end
      abk_pkg::DS_PREP: st_d = abk_pkg::DS_CHK;
      abk_pkg::DS_CHK:  st_d = ovf ? abk_pkg::DS_FIN : abk_pkg::DS_RUN;
      abk_pkg::DS_RUN:  st_d = (cnt_q == 5'd31) ? abk_pkg::DS_FIN : abk_pkg::DS_RUN;
      default:          st_d = abk_pkg::DS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= abk_pkg::DS_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      abk_pkg::DS_PREP: begin
        na_q  <= req_i.num[31] ? 32'(-req_i.num) : req_i.num;
        da_q  <= req_i.den[32] ? 33'(-req_i.den) : req_i.den;
        neg_q <= req_i.num[31] ^ req_i.den[32];
      end
      abk_pkg::DS_CHK: begin
        sat_q <= ovf;
        rem_q <= {9'd0, n_full[55:32]};
        nlo_q <= n_full[31:0];
        quo_q <= '0;
        cnt_q <= '0;
      end
      abk_pkg::DS_RUN: begin
        if (!trial[34]) begin
          rem_q <= trial[32:0];
        end else begin
          rem_q <= {rem_q[31:0], nlo_q[31]};
        end
        quo_q <= {quo_q[30:0], ~trial[34]};
        nlo_q <= {nlo_q[30:0], 1'b0};
        cnt_q <= cnt_q + 5'd1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_o.done = (st_q == abk_pkg::DS_FIN);
    if (sat_q) begin
      rsp_o.gain = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      rsp_o.gain = neg_q ? -$signed(quo_q) : $signed(quo_q);
    end
  end

endmodule

### rtl/core/angle_bias_kalman_filter.sv
// two-state kalman filter: angle and gyro bias with a 2x2 covariance
// input channel: in_valid_i / in_stall_o carry one request of type in_t
//   kind update: predict over time_step, then correct with measured_angle
//   kind reset: seeds angle and bias, clears rate and covariance except
//   p11, takes effect at once and produces no result
// output channel: out_valid_o / out_stall_i carry filtered_angle and
//   corrected_rate, held in an output register until taken
// config channel: cfg_valid_i / cfg_ready_o write q_angle, q_bias,
//   r_measure by index; ready is always high; writes only while idle
//   is a rule for the user, the block itself does not enforce it
// an update finishes sooner when a gain saturates or the innovation
//   covariance is zero; one update at a time, in_stall_o is high until
//   the result is registered
// the two gain divisions in the serial divider (one quotient bit per
//   cycle) take most of an update's time, the shared 35x33 multiplier
//   runs ten products per update
// if the previous result is still stalled, the new one waits in the
//   sequencer and the input stays stalled
// reset: all estimates and covariances clear, noise terms take defaults
module angle_bias_kalman_filter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  abk_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output abk_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [30:0]    cfg_data_i
);

  abk_pkg::st_e       st_q, st_d;
  abk_pkg::mop_e      mop_d, wb_q;
  abk_pkg::div_req_t  div_req;
  abk_pkg::div_rsp_t  div_rsp;

  // filter state
  logic signed [31:0] angle_q, bias_q, rate_q;
  logic signed [31:0] p00_q, p01_q, p10_q, p11_q;
  logic        [30:0] qa_q, qb_q, r_q;

  // per-update working registers
  logic        [23:0] dt_q;
  logic signed [31:0] meas_q;
  logic signed [33:0] inner_q;
  logic signed [32:0] s_q;
  logic signed [31:0] y_q;
  logic signed [31:0] k0_q, k1_q;
  logic signed [31:0] p00s_q, p01s_q;
  logic               out_valid_q;
  abk_pkg::out_t      out_q;

  logic signed [34:0] mul_a;
  logic signed [32:0] mul_b;
  logic               mul_cov;
  logic signed [43:0] mul_rnd;
  logic signed [47:0] rnd48;
  logic signed [47:0] inner_w;
  logic signed [32:0] s_w;
  logic               in_acc;
  logic               out_free;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (st_q != abk_pkg::ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign rnd48   = {{4{mul_rnd[43]}}, mul_rnd};
  assign s_w     = {p00_q[31], p00_q} + {2'b00, r_q};
  assign inner_w = rnd48 - {{16{p01_q[31]}}, p01_q} - {{16{p10_q[31]}}, p10_q}
                   + {17'd0, qa_q};

  // shared multiplier, rounds by the format of the non-dt operand
  abk_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .cov_i (mul_cov),
    .rnd_o (mul_rnd)
  );

  abk_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer: next state, multiplier operands, divider request
  always_comb begin
    st_d          = st_q;
    mop_d         = abk_pkg::MOP_NONE;
    mul_a         = '0;
    mul_b         = {9'd0, dt_q};
    mul_cov       = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = p00_q;
    div_req.den   = s_q;
    unique case (st_q)
      abk_pkg::ST_IDLE: begin
        if (in_acc && in_data_i.kind == abk_pkg::KIND_UPDATE) begin
          st_d = abk_pkg::ST_ANG;
        end
      end
      abk_pkg::ST_ANG: begin
        mop_d = abk_pkg::MOP_ANG;
        mul_a = {{3{rate_q[31]}}, rate_q};
        st_d  = abk_pkg::ST_T;
      end
      abk_pkg::ST_T: begin
        mop_d = abk_pkg::MOP_T;
        mul_a = {{3{p11_q[31]}}, p11_q};
        st_d  = abk_pkg::ST_QB;
      end
      abk_pkg::ST_QB: begin
        mop_d = abk_pkg::MOP_QB;
        mul_a = {4'd0, qb_q};
        st_d  = abk_pkg::ST_P00;
      end
      abk_pkg::ST_P00: begin
        mop_d = abk_pkg::MOP_P00;
        mul_a = {inner_q[33], inner_q};
        st_d  = abk_pkg::ST_WB_P00;
      end
      abk_pkg::ST_WB_P00: st_d = abk_pkg::ST_S;
      abk_pkg::ST_S: begin
        // zero innovation covariance leaves the predicted state as is
        if (s_w == '0) begin
          st_d = abk_pkg::ST_OUT;
        end else begin
          div_req.start = 1'b1;
          div_req.den   = s_w;
          st_d          = abk_pkg::ST_DIV0;
        end
      end
      abk_pkg::ST_DIV0: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = p10_q;
          st_d          = abk_pkg::ST_DIV1;
        end
      end
      abk_pkg::ST_DIV1: begin
        // divider loads its operands in the cycle after the start
        div_req.num = p10_q;
        if (div_rsp.done) begin
          st_d = abk_pkg::ST_K0Y;
        end
      end
      abk_pkg::ST_K0Y: begin
        mop_d   = abk_pkg::MOP_K0Y;
        mul_a   = {{3{k0_q[31]}}, k0_q};
        mul_b   = {y_q[31], y_q};
        mul_cov = 1'b1;
        st_d    = abk_pkg::ST_K1Y;
      end
      abk_pkg::ST_K1Y: begin
        mop_d   = abk_pkg::MOP_K1Y;
        mul_a   = {{3{k1_q[31]}}, k1_q};
        mul_b   = {y_q[31], y_q};
        mul_cov = 1'b1;
        st_d    = abk_pkg::ST_K0P00;
      end
      abk_pkg::ST_K0P00: begin
        mop_d   = abk_pkg::MOP_K0P00;
        mul_a   = {{3{k0_q[31]}}, k0_q};
        mul_b   = {p00s_q[31], p00s_q};
        mul_cov = 1'b1;
        st_d    = abk_pkg::ST_K0P01;
      end
      abk_pkg::ST_K0P01: begin
        mop_d   = abk_pkg::MOP_K0P01;
        mul_a   = {{3{k0_q[31]}}, k0_q};
        mul_b   = {p01s_q[31], p01s_q};
        mul_cov = 1'b1;
        st_d    = abk_pkg::ST_K1P00;
      end
      abk_pkg::ST_K1P00: begin
        mop_d   = abk_pkg::MOP_K1P00;
        mul_a   = {{3{k1_q[31]}}, k1_q};
        mul_b   = {p00s_q[31], p00s_q};
        mul_cov = 1'b1;
        st_d    = abk_pkg::ST_K1P01;
      end
      abk_pkg::ST_K1P01: begin
        mop_d   = abk_pkg::MOP_K1P01;
        mul_a   = {{3{k1_q[31]}}, k1_q};
        mul_b   = {p01s_q[31], p01s_q};
        mul_cov = 1'b1;
        st_d    = abk_pkg::ST_WB_LAST;
      end
      abk_pkg::ST_WB_LAST: st_d = abk_pkg::ST_OUT;
      abk_pkg::ST_OUT: begin
        if (out_free) begin
          st_d = abk_pkg::ST_IDLE;
        end
      end
      default: st_d = abk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= abk_pkg::ST_IDLE;
      wb_q <= abk_pkg::MOP_NONE;
    end else begin
      st_q <= st_d;
      wb_q <= mop_d;
    end
  end

  // filter state: seeding, rate update, config writes and product write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      bias_q  <= '0;
      rate_q  <= '0;
      p00_q   <= '0;
      p01_q   <= '0;
      p10_q   <= '0;
      p11_q   <= '0;
      qa_q    <= abk_pkg::QAngleReset;
      qb_q    <= abk_pkg::QBiasReset;
      r_q     <= abk_pkg::RMeasureReset;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          abk_pkg::CFG_Q_ANGLE:   qa_q <= cfg_data_i;
          abk_pkg::CFG_Q_BIAS:    qb_q <= cfg_data_i;
          abk_pkg::CFG_R_MEASURE: r_q  <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        if (in_data_i.kind == abk_pkg::KIND_RESET) begin
          angle_q <= in_data_i.seed_angle;
          bias_q  <= in_data_i.seed_bias;
          rate_q  <= '0;
          p00_q   <= '0;
          p01_q   <= '0;
          p10_q   <= '0;
          p11_q   <= abk_pkg::P11Seed;
        end else begin
          rate_q <= abk_pkg::sat32({{16{in_data_i.gyro_rate[31]}}, in_data_i.gyro_rate}
                                   - {{16{bias_q[31]}}, bias_q});
        end
      end
      case (wb_q)
        abk_pkg::MOP_ANG: begin
          angle_q <= abk_pkg::sat32({{16{angle_q[31]}}, angle_q} + rnd48);
        end
        abk_pkg::MOP_T: begin
          p01_q <= abk_pkg::sat32({{16{p01_q[31]}}, p01_q} - rnd48);
          p10_q <= abk_pkg::sat32({{16{p10_q[31]}}, p10_q} - rnd48);
        end
        abk_pkg::MOP_QB: begin
          p11_q <= abk_pkg::sat32({{16{p11_q[31]}}, p11_q} + rnd48);
        end
        abk_pkg::MOP_P00: begin
          p00_q <= abk_pkg::sat32({{16{p00_q[31]}}, p00_q} + rnd48);
        end
        abk_pkg::MOP_K0Y: begin
          angle_q <= abk_pkg::sat32({{16{angle_q[31]}}, angle_q} + rnd48);
        end
        abk_pkg::MOP_K1Y: begin
          bias_q <= abk_pkg::sat32({{16{bias_q[31]}}, bias_q} + rnd48);
        end
        abk_pkg::MOP_K0P00: begin
          p00_q <= abk_pkg::sat32({{16{p00_q[31]}}, p00_q} - rnd48);
        end
        abk_pkg::MOP_K0P01: begin
          p01_q <= abk_pkg::sat32({{16{p01_q[31]}}, p01_q} - rnd48);
        end
        abk_pkg::MOP_K1P00: begin
          p10_q <= abk_pkg::sat32({{16{p10_q[31]}}, p10_q} - rnd48);
        end
        abk_pkg::MOP_K1P01: begin
          p11_q <= abk_pkg::sat32({{16{p11_q[31]}}, p11_q} - rnd48);
        end
        default: begin
        end
      endcase
    end
  end

  // working registers of the current update
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dt_q   <= in_data_i.time_step;
      meas_q <= in_data_i.measured_angle;
    end
    // inner term uses p01/p10 before they drop by t
    if (wb_q == abk_pkg::MOP_T) begin
      inner_q <= inner_w[33:0];
    end
    if (st_q == abk_pkg::ST_S) begin
      s_q    <= s_w;
      p00s_q <= p00_q;
      p01s_q <= p01_q;
      y_q    <= abk_pkg::sat32({{16{meas_q[31]}}, meas_q} - {{16{angle_q[31]}}, angle_q});
    end
    if (st_q == abk_pkg::ST_DIV0 && div_rsp.done) begin
      k0_q <= div_rsp.gain;
    end
    if (st_q == abk_pkg::ST_DIV1 && div_rsp.done) begin
      k1_q <= div_rsp.gain;
    end
    if (st_q == abk_pkg::ST_OUT && out_free) begin
      out_q.filtered_angle <= angle_q;
      out_q.corrected_rate <= rate_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_q == abk_pkg::ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

### rtl/core/abk_checker.sv
`include "assert_macros.svh"

module abk_props (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input abk_pkg::in_t   in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input abk_pkg::out_t  out_data_o,
  input logic           cfg_valid_i,
  input logic           cfg_ready_o,
  input logic [1:0]     cfg_index_i,
  input logic [30:0]    cfg_data_i
);

  logic upd_acc;
  logic seed_acc;

  assign upd_acc  = in_valid_i && !in_stall_o && in_data_i.kind == abk_pkg::KIND_UPDATE;
  assign seed_acc = in_valid_i && !in_stall_o && in_data_i.kind == abk_pkg::KIND_RESET;

  // a stalled result stays and keeps its value
  `ABK_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
            out_valid_o && $stable(out_data_o), "stalled result changed")

  // an update keeps the input stalled while it runs
  `ABK_NEXT(a_upd_busy, clk_i, rst_ni, upd_acc, in_stall_o, "input open during update")

  // a seed request never produces a result
  `ABK_NEXT(a_seed_silent, clk_i, rst_ni, seed_acc && !out_valid_o, !out_valid_o,
            "result after seed request")

  // config writes are always taken
  `ABK_ASSERT(a_cfg_ready, clk_i, rst_ni, !cfg_valid_i || cfg_ready_o, "config write refused")

endmodule

bind angle_bias_kalman_filter abk_props u_abk_props (.*);
